// File: hw/rtl/qej_pkg.sv
// shared types and constants of the quaternion to euler jacobian pipeline
package qej_pkg;

   localparam int QUAT_W    = 16;
   localparam int SUM_W     = QUAT_W + 1;
   localparam int SQR_W     = 2 * QUAT_W + 1;
   localparam int DEN_W     = 34;
   localparam int PM_W      = 29;
   localparam int RAD_W     = 63;
   localparam int SQ_STEPS  = 32;
   localparam int G_W       = 32;
   localparam int NUM_W     = 49;
   localparam int QUO_W     = 33;
   localparam int DIV_STEPS = QUO_W;
   localparam int ENTRY_W   = 32;
   localparam int LANES     = 4;
   localparam int SHIFT_ROT = 31;
   localparam int SHIFT_PIT = 33;

   localparam logic signed [ENTRY_W-1:0] SAT_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
   localparam logic signed [ENTRY_W-1:0] SAT_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

   typedef logic [1:0] row_type;
   localparam row_type ROW_ROLL  = 2'd0;
   localparam row_type ROW_PITCH = 2'd1;
   localparam row_type ROW_YAW   = 2'd2;

   typedef struct packed {
      logic                     valid;
      row_type                  row;
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
      logic [DEN_W-1:0]         d1;
      logic [DEN_W-1:0]         d2;
      logic                     zero_den;
      logic                     bad_rad;
   } item_type;

   typedef struct packed {
      logic    valid;
      row_type row;
      logic    zero_den;
      logic    bad_rad;
   } ctl_type;

endpackage

// File: hw/rtl/qej_front.sv
// row sequencer and sums of squares, products and radicand stages
module qej_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [qej_pkg::QUAT_W-1:0] req_quat_w,
   input  logic signed [qej_pkg::QUAT_W-1:0] req_quat_x,
   input  logic signed [qej_pkg::QUAT_W-1:0] req_quat_y,
   input  logic signed [qej_pkg::QUAT_W-1:0] req_quat_z,
   output qej_pkg::item_type                 item_out,
   output logic [qej_pkg::RAD_W-1:0]         rad_out
);
   import qej_pkg::*;

   logic                     busy_ff;
   row_type                  phase_ff;
   logic signed [QUAT_W-1:0] w_ff, x_ff, y_ff, z_ff;
   logic                     take;

   logic                     s1_valid_ff;
   row_type                  s1_row_ff;
   logic signed [QUAT_W-1:0] s1_w_ff, s1_x_ff, s1_y_ff, s1_z_ff;
   logic [SQR_W-1:0]         s1_aa_ff, s1_bb_ff, s1_cc_ff, s1_dd_ff;
   logic signed [2*QUAT_W-1:0] s1_yz_ff, s1_xw_ff;

   logic signed [SUM_W-1:0]   a_s, b_s, c_s, d_s;
   logic signed [2*SUM_W-1:0] aa_p, bb_p, cc_p, dd_p;

   item_type               s2_ff, s2_in;
   logic [PM_W-1:0]        s2_pm_ff;
   logic signed [2*QUAT_W:0] p_s;
   logic [2*QUAT_W:0]      pm_s;

   item_type               s3_ff;
   logic [2*PM_W-1:0]      s3_sq_ff;

   item_type               s4_ff;
   logic [RAD_W-1:0]       s4_rad_ff;
   logic [2*PM_W:0]        diff_s;

   assign req_ready = adv && (!busy_ff || phase_ff == ROW_YAW);
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= ROW_ROLL;
      end else if (adv) begin
         if (take) begin
            busy_ff  <= 1'b1;
            phase_ff <= ROW_ROLL;
         end else if (busy_ff && phase_ff == ROW_YAW) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            phase_ff <= phase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         w_ff <= req_quat_w;
         x_ff <= req_quat_x;
         y_ff <= req_quat_y;
         z_ff <= req_quat_z;
      end
   end

   always_comb begin
      a_s  = SUM_W'(w_ff) + SUM_W'(x_ff);
      b_s  = SUM_W'(z_ff) + SUM_W'(y_ff);
      c_s  = SUM_W'(w_ff) - SUM_W'(x_ff);
      d_s  = SUM_W'(z_ff) - SUM_W'(y_ff);
      aa_p = a_s * a_s;
      bb_p = b_s * b_s;
      cc_p = c_s * c_s;
      dd_p = d_s * d_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_row_ff <= phase_ff;
         s1_w_ff   <= w_ff;
         s1_x_ff   <= x_ff;
         s1_y_ff   <= y_ff;
         s1_z_ff   <= z_ff;
         s1_aa_ff  <= aa_p[SQR_W-1:0];
         s1_bb_ff  <= bb_p[SQR_W-1:0];
         s1_cc_ff  <= cc_p[SQR_W-1:0];
         s1_dd_ff  <= dd_p[SQR_W-1:0];
         s1_yz_ff  <= y_ff * z_ff;
         s1_xw_ff  <= x_ff * w_ff;
      end
   end

   always_comb begin
      p_s            = (2*QUAT_W+1)'(s1_yz_ff) + (2*QUAT_W+1)'(s1_xw_ff);
      pm_s           = p_s[2*QUAT_W] ? (2*QUAT_W+1)'(-p_s) : p_s;
      s2_in.valid    = s1_valid_ff;
      s2_in.row      = s1_row_ff;
      s2_in.w        = s1_w_ff;
      s2_in.x        = s1_x_ff;
      s2_in.y        = s1_y_ff;
      s2_in.z        = s1_z_ff;
      s2_in.d1       = DEN_W'(s1_aa_ff) + DEN_W'(s1_bb_ff);
      s2_in.d2       = DEN_W'(s1_cc_ff) + DEN_W'(s1_dd_ff);
      s2_in.zero_den = (s2_in.d1 == '0) || (s2_in.d2 == '0);
      s2_in.bad_rad  = |pm_s[2*QUAT_W:PM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (adv) begin
         s2_ff <= s2_in;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
   end

   assign diff_s = ((2*PM_W+1)'(1) << (2*PM_W)) - {1'b0, s3_sq_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pm_ff  <= pm_s[PM_W-1:0];
         s3_sq_ff  <= s2_pm_ff * s2_pm_ff;
         s4_rad_ff <= {diff_s, 4'b0000};
      end
   end

   assign item_out = s4_ff;
   assign rad_out  = s4_rad_ff;

endmodule

// File: hw/rtl/qej_sqrt.sv
// pipelined integer square root, two radicand bits per stage
module qej_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  qej_pkg::item_type         item_in,
   input  logic [qej_pkg::RAD_W-1:0] rad_in,
   output qej_pkg::item_type         item_out,
   output logic [qej_pkg::G_W-1:0]   g_out
);
   import qej_pkg::*;

   item_type         it_ff  [SQ_STEPS];
   logic [RAD_W-1:0] n_ff   [SQ_STEPS];
   logic [RAD_W-1:0] res_ff [SQ_STEPS];

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 1 - 2 * k);
      item_type         it_prev;
      logic [RAD_W-1:0] n_prev, r_prev, n_in, res_in;
      logic [RAD_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign it_prev = item_in;
         assign n_prev  = rad_in;
         assign r_prev  = '0;
      end else begin : g_next
         assign it_prev = it_ff[k-1];
         assign n_prev  = n_ff[k-1];
         assign r_prev  = res_ff[k-1];
      end

      always_comb begin
         trial  = {1'b0, r_prev} + {1'b0, BIT};
         ge     = {1'b0, n_prev} >= trial;
         n_in   = ge ? n_prev - trial[RAD_W-1:0] : n_prev;
         res_in = ge ? (r_prev >> 1) + BIT : r_prev >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_ff[k].valid <= 1'b0;
         end else if (adv) begin
            it_ff[k] <= it_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[k]   <= n_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign item_out = it_ff[SQ_STEPS-1];
   assign g_out    = res_ff[SQ_STEPS-1][G_W-1:0];

endmodule

// File: hw/rtl/qej_div.sv
// four-lane pipelined restoring divider, one quotient bit per stage
module qej_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  qej_pkg::ctl_type                        ctl_in,
   input  logic [qej_pkg::NUM_W-1:0]               num_in [qej_pkg::LANES],
   input  logic [qej_pkg::DEN_W-1:0]               den_in [qej_pkg::LANES],
   input  logic                                    neg_in [qej_pkg::LANES],
   output qej_pkg::ctl_type                        ctl_out,
   output logic signed [qej_pkg::QUO_W:0]          quo_out [qej_pkg::LANES]
);
   import qej_pkg::*;

   localparam int CMP_W = DEN_W + DIV_STEPS;

   ctl_type          ctl_ff [DIV_STEPS];
   logic [NUM_W-1:0] rem_ff [DIV_STEPS][LANES];
   logic [DEN_W-1:0] den_ff [DIV_STEPS][LANES];
   logic             neg_ff [DIV_STEPS][LANES];
   logic [QUO_W-1:0] q_ff   [DIV_STEPS][LANES];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
      localparam int J = DIV_STEPS - 1 - k;
      ctl_type ctl_prev;

      if (k == 0) begin : g_first_ctl
         assign ctl_prev = ctl_in;
      end else begin : g_next_ctl
         assign ctl_prev = ctl_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_prev;
         end
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NUM_W-1:0] rem_prev, rem_in;
         logic [DEN_W-1:0] den_prev;
         logic             neg_prev;
         logic [QUO_W-1:0] q_prev, q_in;
         logic [CMP_W-1:0] dsh;
         logic             ge;

         if (k == 0) begin : g_first
            assign rem_prev = num_in[l];
            assign den_prev = den_in[l];
            assign neg_prev = neg_in[l];
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1][l];
            assign den_prev = den_ff[k-1][l];
            assign neg_prev = neg_ff[k-1][l];
            assign q_prev   = q_ff[k-1][l];
         end

         always_comb begin
            dsh    = CMP_W'(den_prev) << J;
            ge     = CMP_W'(rem_prev) >= dsh;
            rem_in = ge ? rem_prev - dsh[NUM_W-1:0] : rem_prev;
            q_in   = q_prev;
            q_in[J] = ge;
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][l] <= rem_in;
               den_ff[k][l] <= den_prev;
               neg_ff[k][l] <= neg_prev;
               q_ff[k][l]   <= q_in;
            end
         end
      end
   end

   assign ctl_out = ctl_ff[DIV_STEPS-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo_out[l] = neg_ff[DIV_STEPS-1][l] ? -$signed({1'b0, q_ff[DIV_STEPS-1][l]})
                                             : $signed({1'b0, q_ff[DIV_STEPS-1][l]});
      end
   end

endmodule

// File: hw/rtl/quaternion_euler_jacobian.sv
// top level of the quaternion to euler angle jacobian pipeline
//
// One quaternion (w,x,y,z, signed Q1.15) is taken on the req_ channel per
// transfer and gives three rsp_ transfers, rows roll, pitch and yaw in that
// order, each with four signed Q16.16 entries; rsp_last_row marks the yaw row
// and rsp_singular is the same on all three rows.
// A row sequencer issues one row per cycle into a single stall-all pipeline:
// products and sums of squares (4 stages), a square root of 32 stages, lane
// set-up (1 stage), a four-lane divider of 33 stages and a combine and
// saturate stage that is also the output register.
// Throughput: one row per cycle while the receiver does not stall, set by the
// single result channel carrying one row per transfer; a new quaternion is
// taken while the sequencer is idle or issues the yaw row of the one before.
// Reset (synchronous, active high) empties the sequencer and clears every
// stage valid bit; no clearing pass is needed.
// When the receiver stalls the whole pipeline holds, the held row stays on
// the rsp_ ports and req_ready drops; nothing is lost or repeated.
module quaternion_euler_jacobian (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [qej_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic signed [qej_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [qej_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [qej_pkg::QUAT_W-1:0]   req_quat_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_row_index,
   output logic signed [qej_pkg::ENTRY_W-1:0]  rsp_entry_w,
   output logic signed [qej_pkg::ENTRY_W-1:0]  rsp_entry_x,
   output logic signed [qej_pkg::ENTRY_W-1:0]  rsp_entry_y,
   output logic signed [qej_pkg::ENTRY_W-1:0]  rsp_entry_z,
   output logic                                rsp_singular,
   output logic                                rsp_last_row
);
   import qej_pkg::*;

   logic             adv;
   item_type         front_item, sq_item;
   logic [RAD_W-1:0] front_rad;
   logic [G_W-1:0]   g_val;

   ctl_type          prep_ctl_ff;
   logic [NUM_W-1:0] prep_num_ff [LANES];
   logic [DEN_W-1:0] prep_den_ff [LANES];
   logic             prep_neg_ff [LANES];

   logic signed [QUAT_W:0]   val_s [LANES];
   logic [DEN_W-1:0]         den_s [LANES];
   logic [QUAT_W:0]          mag_s;
   logic [NUM_W-1:0]         num_s [LANES];
   logic                     neg_s [LANES];

   ctl_type                  div_ctl;
   logic signed [QUO_W:0]    quo [LANES];
   logic signed [QUO_W+1:0]  qa, qb, qc, qe;
   logic signed [QUO_W+1:0]  sum_s [LANES];
   logic signed [ENTRY_W-1:0] ent_s [LANES];

   logic                      rsp_valid_ff;
   row_type                   rsp_row_ff;
   logic signed [ENTRY_W-1:0] rsp_ent_ff [LANES];
   logic                      rsp_sing_ff;

   assign adv = !rsp_valid_ff || rsp_ready;

   qej_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .item_out   (front_item),
      .rad_out    (front_rad)
   );

   qej_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .item_in  (front_item),
      .rad_in   (front_rad),
      .item_out (sq_item),
      .g_out    (g_val)
   );

   // lane order: pitch row w,z,y,x over g; other rows b,a,d,c over d1,d1,d2,d2
   always_comb begin
      mag_s = '0;
      if (sq_item.row == ROW_PITCH) begin
         val_s[0] = (QUAT_W+1)'(sq_item.w);
         val_s[1] = (QUAT_W+1)'(sq_item.z);
         val_s[2] = (QUAT_W+1)'(sq_item.y);
         val_s[3] = (QUAT_W+1)'(sq_item.x);
         for (int l = 0; l < LANES; l++) begin
            den_s[l] = DEN_W'(g_val);
         end
      end else begin
         val_s[0] = (QUAT_W+1)'(sq_item.z) + (QUAT_W+1)'(sq_item.y);
         val_s[1] = (QUAT_W+1)'(sq_item.w) + (QUAT_W+1)'(sq_item.x);
         val_s[2] = (QUAT_W+1)'(sq_item.z) - (QUAT_W+1)'(sq_item.y);
         val_s[3] = (QUAT_W+1)'(sq_item.w) - (QUAT_W+1)'(sq_item.x);
         den_s[0] = sq_item.d1;
         den_s[1] = sq_item.d1;
         den_s[2] = sq_item.d2;
         den_s[3] = sq_item.d2;
      end
      for (int l = 0; l < LANES; l++) begin
         neg_s[l] = val_s[l][QUAT_W];
         mag_s    = neg_s[l] ? (QUAT_W+1)'(-val_s[l]) : val_s[l];
         num_s[l] = (sq_item.row == ROW_PITCH) ? NUM_W'(mag_s) << SHIFT_PIT
                                               : NUM_W'(mag_s) << SHIFT_ROT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         prep_ctl_ff.valid    <= sq_item.valid;
         prep_ctl_ff.row      <= sq_item.row;
         prep_ctl_ff.zero_den <= sq_item.zero_den;
         prep_ctl_ff.bad_rad  <= sq_item.bad_rad;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            prep_num_ff[l] <= num_s[l];
            prep_den_ff[l] <= den_s[l];
            prep_neg_ff[l] <= neg_s[l];
         end
      end
   end

   qej_div u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (prep_ctl_ff),
      .num_in  (prep_num_ff),
      .den_in  (prep_den_ff),
      .neg_in  (prep_neg_ff),
      .ctl_out (div_ctl),
      .quo_out (quo)
   );

   always_comb begin
      qa = (QUO_W+2)'(quo[0]);
      qb = (QUO_W+2)'(quo[1]);
      qc = (QUO_W+2)'(quo[2]);
      qe = (QUO_W+2)'(quo[3]);
      case (div_ctl.row)
         ROW_ROLL: begin
            sum_s[0] = qc - qa;
            sum_s[1] = qb - qe;
            sum_s[2] = qb + qe;
            sum_s[3] = -qa - qc;
         end
         ROW_YAW: begin
            sum_s[0] = -qa - qc;
            sum_s[1] = qb + qe;
            sum_s[2] = qb - qe;
            sum_s[3] = qc - qa;
         end
         default: begin
            sum_s[0] = qa;
            sum_s[1] = qb;
            sum_s[2] = qc;
            sum_s[3] = qe;
         end
      endcase
      for (int l = 0; l < LANES; l++) begin
         if ((div_ctl.row == ROW_PITCH && div_ctl.bad_rad) ||
             (div_ctl.row != ROW_PITCH && div_ctl.zero_den)) begin
            ent_s[l] = SAT_MAX;
         end else if (sum_s[l] > (QUO_W+2)'(SAT_MAX)) begin
            ent_s[l] = SAT_MAX;
         end else if (sum_s[l] < (QUO_W+2)'(SAT_MIN)) begin
            ent_s[l] = SAT_MIN;
         end else begin
            ent_s[l] = sum_s[l][ENTRY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_row_ff  <= div_ctl.row;
         rsp_sing_ff <= div_ctl.zero_den || div_ctl.bad_rad;
         for (int l = 0; l < LANES; l++) begin
            rsp_ent_ff[l] <= ent_s[l];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_entry_w   = rsp_ent_ff[0];
   assign rsp_entry_x   = rsp_ent_ff[1];
   assign rsp_entry_y   = rsp_ent_ff[2];
   assign rsp_entry_z   = rsp_ent_ff[3];
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_last_row  = rsp_valid_ff && rsp_row_ff == ROW_YAW;

   a_ready_needs_adv: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input taken while the output row is stalled");

   a_roll_after_yaw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_row_index == ROW_ROLL) |=>
      !(rsp_valid && rsp_row_index == ROW_ROLL))
      else $error("roll row repeated without pitch and yaw rows");

   a_pitch_follows_roll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_row_index == ROW_ROLL) |=>
      (rsp_valid && rsp_row_index == ROW_PITCH))
      else $error("pitch row does not follow roll row");

endmodule

// File: sim/quaternion_euler_jacobian_tb.sv
// self-checking testbench of the quaternion to euler angle jacobian block
module quaternion_euler_jacobian_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import qej_pkg::*;

   typedef struct {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   typedef struct {
      logic [1:0]         row;
      logic signed [31:0] e [4];
      logic               sing;
      logic               last;
   } exp_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_entry_w, rsp_entry_x, rsp_entry_y, rsp_entry_z;
   logic rsp_singular, rsp_last_row;

   quat_type    pending_quats[$];
   exp_row_type expected_rows[$];
   int    mismatches = 0;
   bit    stimulus_done = 1'b0;
   bit    req_taken = 1'b0;
   int    hold_off = 0;
   int    burst_left = 0;
   int    gap_left = 0;

   quaternion_euler_jacobian i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint trunc_div(longint num, longint den);
      longint q;
      q = (num < 0 ? -num : num) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return SAT_MAX;
      if (v < -64'sd2147483648) return SAT_MIN;
      return v[31:0];
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   task automatic predict_jacobian_rows(quat_type q);
      longint w, x, y, z, a, b, c, d, d1, d2, p, pm, g;
      longint ta, tb, tc, te;
      longint r0 [4], r1 [4], r2 [4];
      bit zero_den, bad_rad;
      exp_row_type r;
      w = q.w; x = q.x; y = q.y; z = q.z;
      a = w + x; b = z + y; c = w - x; d = z - y;
      d1 = a * a + b * b;
      d2 = c * c + d * d;
      p = y * z + x * w;
      pm = p < 0 ? -p : p;
      zero_den = (d1 == 0) || (d2 == 0);
      bad_rad = pm >= (64'sd1 << 29);
      if (zero_den) begin
         r0 = '{default: 64'sd2147483647};
         r2 = '{default: 64'sd2147483647};
      end else begin
         ta = trunc_div(b <<< 31, d1);
         tb = trunc_div(a <<< 31, d1);
         tc = trunc_div(d <<< 31, d2);
         te = trunc_div(c <<< 31, d2);
         r0 = '{-ta + tc, tb - te, tb + te, -ta - tc};
         r2 = '{-ta - tc, tb + te, tb - te, -ta + tc};
      end
      if (bad_rad) begin
         r1 = '{default: 64'sd2147483647};
      end else begin
         g = int_sqrt(((64'd1 << 58) - pm * pm) << 4);
         r1 = '{trunc_div(w <<< 33, g), trunc_div(z <<< 33, g),
                trunc_div(y <<< 33, g), trunc_div(x <<< 33, g)};
      end
      for (int k = 0; k < 3; k++) begin
         r.row = k[1:0];
         for (int j = 0; j < 4; j++)
            r.e[j] = clamp32(k == 0 ? r0[j] : (k == 1 ? r1[j] : r2[j]));
         r.sing = zero_den || bad_rad;
         r.last = (k == 2);
         expected_rows.push_back(r);
      end
   endtask

   function automatic logic signed [15:0] pick_component();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return 16'($urandom_range(0, 15) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic quat_type unit_quat();
      real v [4];
      real n;
      quat_type q;
      n = 0.0;
      for (int k = 0; k < 4; k++) begin
         v[k] = $itor($signed($urandom_range(0, 65535)) - 32768);
         n += v[k] * v[k];
      end
      if (n == 0.0) begin
         v[0] = 1.0;
         n = 1.0;
      end
      n = $sqrt(n);
      q.w = 16'($rtoi(v[0] / n * 32000.0));
      q.x = 16'($rtoi(v[1] / n * 32000.0));
      q.y = 16'($rtoi(v[2] / n * 32000.0));
      q.z = 16'($rtoi(v[3] / n * 32000.0));
      return q;
   endfunction

   function automatic quat_type mk(int w, int x, int y, int z);
      quat_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            end
            if (hold_off > 0 || gap_left > 0 || pending_quats.size() == 0) begin
               if (hold_off > 0 && expected_rows.size() == 0 && !req_taken) hold_off = 0;
               else if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               quat_type q;
               q = pending_quats.pop_front();
               req_valid <= 1'b1;
               req_quat_w <= q.w;
               req_quat_x <= q.x;
               req_quat_y <= q.y;
               req_quat_z <= q.z;
               burst_left--;
               if (pending_quats.size() == 215) hold_off = 1;
            end
         end
         req_taken = 1'b0;
         if ($time / 2000 % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_jacobian_rows('{req_quat_w, req_quat_x, req_quat_y, req_quat_z});
         req_taken = 1'b1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row transfer, row %0d", rsp_row_index);
         end else begin
            exp_row_type r;
            r = expected_rows.pop_front();
            if (r.row !== rsp_row_index || r.e[0] !== rsp_entry_w ||
                r.e[1] !== rsp_entry_x || r.e[2] !== rsp_entry_y ||
                r.e[3] !== rsp_entry_z || r.sing !== rsp_singular ||
                r.last !== rsp_last_row) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp row %0d %0d %0d %0d %0d s%0d l%0d, got row %0d %0d %0d %0d %0d s%0d l%0d",
                     r.row, r.e[0], r.e[1], r.e[2], r.e[3], r.sing, r.last,
                     rsp_row_index, rsp_entry_w, rsp_entry_x, rsp_entry_y,
                     rsp_entry_z, rsp_singular, rsp_last_row);
            end
         end
      end
   end

   initial begin
      pending_quats.push_back(mk(0, 0, 0, 0));
      pending_quats.push_back(mk(32767, 0, 0, 0));
      pending_quats.push_back(mk(-32768, 0, 0, 0));
      pending_quats.push_back(mk(16384, 16384, 0, 0));
      pending_quats.push_back(mk(16384, -16384, 16384, 16384));
      pending_quats.push_back(mk(23170, 0, 23170, 0));
      pending_quats.push_back(mk(23170, 23170, 0, 0));
      pending_quats.push_back(mk(0, 0, 23170, 23170));
      pending_quats.push_back(mk(32767, 32767, 32767, 32767));
      pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
      pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
      pending_quats.push_back(mk(1, 0, 0, 0));
      pending_quats.push_back(mk(0, 0, 0, -1));
      pending_quats.push_back(mk(16384, 16384, 16384, 16384));
      pending_quats.push_back(mk(100, -100, 100, -100));
      pending_quats.push_back(mk(32767, -32768, 0, 0));
      for (int k = 0; k < 415; k++) begin
         if ($urandom_range(0, 3) != 0) pending_quats.push_back(unit_quat());
         else pending_quats.push_back(mk(pick_component(), pick_component(),
                                         pick_component(), pick_component()));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_quats.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      wait (expected_rows.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rows.size() == 0)
         $display("** quaternion_euler_jacobian: PASSED **");
      else
         $display("** quaternion_euler_jacobian: FAILED **");
      $finish;
   end

   initial begin
      #2ms;
      $display("** quaternion_euler_jacobian: FAILED **");
      $finish;
   end
endmodule
